FILE: rtl/core/msb_first_bit_reader_core_macros.svh
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core_macros.svh
// Assertion helpers for the MSB-first bit reader.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_READER_CORE_MACROS_SVH
`define MSB_FIRST_BIT_READER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MFBR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mfbr assertion failed");

// next-cycle implication, disabled in reset
`define MFBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mfbr assertion failed");

`endif

FILE: rtl/core/mfbr_pkg.sv
// ----------------------------------------------------------------------------
// mfbr_pkg
// Types and constants shared by the MSB-first bit reader modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfbr_pkg;

  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 16;
  localparam int VALUE_W = 64;
  localparam int LEN_W   = 13;
  localparam int POS_W   = 16;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SKIP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REWIND = 2'd3;

  localparam logic [COUNT_W-1:0] POP_MAX_BITS = 16'd64;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  byte_addr;
    logic [DATA_W-1:0]  byte_data;
    logic [COUNT_W-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic               at_end;
    logic [LEN_W-1:0]   remaining_bytes;
    logic [LEN_W-1:0]   consumed_bytes;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pop_go;
    logic last_issue;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/mfbr_ctrl.sv
// ----------------------------------------------------------------------------
// mfbr_ctrl
// Sequencer: accept, execute, byte read loop, result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfbr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire mfbr_pkg::sts_t sts,
  output mfbr_pkg::cmd_t     cmd
);
  import mfbr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.load   = in_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.pop_go ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfbr_dp.sv
// ----------------------------------------------------------------------------
// mfbr_dp
// Datapath: byte store, bit position, length register, bit assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfbr_dp #(
  parameter int BUF_BYTES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [mfbr_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire mfbr_pkg::in_item_t       in_item,
  input  wire mfbr_pkg::cmd_t           cmd,
  output mfbr_pkg::sts_t                sts,
  output mfbr_pkg::out_item_t           out_item
);
  import mfbr_pkg::*;

  localparam int AW    = $clog2(BUF_BYTES);
  localparam int EXT_W = 17;
  localparam int ACC_W = VALUE_W + DATA_W;

  logic [DATA_W-1:0]  mem [BUF_BYTES];

  in_item_t           item_r;
  logic [POS_W-1:0]   pos_r;
  logic [LEN_W-1:0]   len_r;
  logic               ok_r;
  logic               is_pop_r;
  logic [LEN_W-1:0]   rd_addr_r;
  logic [3:0]         bytes_left_r;
  logic [2:0]         tail_r;
  logic [6:0]         cnt_r;
  logic [ACC_W-1:0]   acc_r;
  logic [DATA_W-1:0]  rdata_r;
  logic               rd_zero_r;
  logic               rd_vld_r;
  out_item_t          out_r;

  logic [POS_W-1:0]   len_bits;
  logic [POS_W:0]     pos_sum;
  logic               fits;
  logic               pop_legal;
  logic               wr_in_range;
  logic               rd_in_range;
  logic [EXT_W-1:0]   wr_ext;
  logic [EXT_W-1:0]   rd_ext;
  logic [7:0]         off_plus_n;
  logic [7:0]         nb_sum;
  logic [ACC_W-1:0]   acc_shift;
  logic [VALUE_W-1:0] pop_mask;
  logic [VALUE_W-1:0] value_fin;
  logic [POS_W:0]     cons_sum;

  assign len_bits    = {len_r, 3'b000};
  assign pos_sum     = {1'b0, pos_r} + {1'b0, item_r.bit_count};
  assign fits        = (pos_sum <= {1'b0, len_bits});
  assign pop_legal   = (item_r.bit_count != '0) && (item_r.bit_count <= POP_MAX_BITS) && fits;
  assign wr_ext      = EXT_W'(item_r.byte_addr);
  assign rd_ext      = EXT_W'(rd_addr_r);
  assign wr_in_range = (wr_ext < EXT_W'(BUF_BYTES));
  assign rd_in_range = (rd_ext < EXT_W'(BUF_BYTES));
  assign off_plus_n  = {5'b0, pos_r[2:0]} + {1'b0, item_r.bit_count[6:0]};
  assign nb_sum      = off_plus_n + 8'd7;

  assign sts.pop_go     = (item_r.kind == KIND_POP) && pop_legal;
  assign sts.last_issue = (bytes_left_r == 4'd1);

  assign acc_shift = acc_r >> tail_r;
  assign pop_mask  = ~({VALUE_W{1'b1}} << cnt_r);
  assign value_fin = (is_pop_r && ok_r) ? (acc_shift[VALUE_W-1:0] & pop_mask) : '0;
  assign cons_sum  = {1'b0, pos_r} + 17'd7;

  assign out_item = out_r;

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.exec && (item_r.kind == KIND_WRITE) && wr_in_range) begin
      mem[wr_ext[AW-1:0]] <= item_r.byte_data;
    end
    if (cmd.issue) begin
      rdata_r   <= mem[rd_ext[AW-1:0]];
      rd_zero_r <= !rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cfg_wr_en) len_r <= cfg_wr_data;
      if (cmd.exec) begin
        unique case (item_r.kind)
          KIND_POP:    if (pop_legal) pos_r <= pos_sum[POS_W-1:0];
          KIND_SKIP:   if (fits) pos_r <= pos_sum[POS_W-1:0];
          KIND_REWIND: pos_r <= '0;
          default:     pos_r <= pos_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.exec) begin
      unique case (item_r.kind)
        KIND_WRITE:  ok_r <= wr_in_range;
        KIND_POP:    ok_r <= pop_legal;
        KIND_SKIP:   ok_r <= fits;
        default:     ok_r <= 1'b1;
      endcase
      is_pop_r     <= (item_r.kind == KIND_POP);
      rd_addr_r    <= pos_r[POS_W-1:3];
      bytes_left_r <= nb_sum[6:3];
      tail_r       <= 3'd0 - off_plus_n[2:0];
      cnt_r        <= item_r.bit_count[6:0];
      acc_r        <= '0;
    end else if (rd_vld_r) begin
      acc_r <= {acc_r[ACC_W-DATA_W-1:0], (rd_zero_r ? {DATA_W{1'b0}} : rdata_r)};
    end
    if (cmd.issue) begin
      rd_addr_r    <= rd_addr_r + LEN_W'(1);
      bytes_left_r <= bytes_left_r - 4'd1;
    end
    if (cmd.finish) begin
      out_r.value           <= value_fin;
      out_r.ok              <= ok_r;
      out_r.at_end          <= (pos_r == len_bits);
      out_r.remaining_bytes <= (pos_r <= len_bits) ?
                               LEN_W'((len_bits - pos_r) >> 3) : '0;
      out_r.consumed_bytes  <= cons_sum[LEN_W+2:3];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/msb_first_bit_reader_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core
// Byte store with an MSB-first bit read position: write, pop, skip, rewind.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one item per beat; every item gives
// exactly one result beat on out_valid/out_ready. cfg_wr_en/cfg_wr_data load
// the stream length in bytes; write it only while the block is idle.
// An item runs through execute and then, for a pop that passes its checks, a
// byte read loop over the nb bytes it touches (1 to 9) and a drain step,
// before the result is loaded. The byte loop reads one byte per cycle from
// the single-port store and sets the pop rate. The next item is taken the
// cycle after a result enters the output register, so items never overlap.
// Reset clears the bit position and the length; store contents are
// undefined until written. A stalled receiver holds the result in the output
// register; one further item is accepted and run, then waits until the
// register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "msb_first_bit_reader_core_macros.svh"

module msb_first_bit_reader_core #(
  parameter int BUF_BYTES = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [mfbr_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mfbr_pkg::in_item_t         in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mfbr_pkg::out_item_t             out_item
);
  import mfbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfbr_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_item    (out_item)
  );

  `MFBR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `MFBR_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.finish, !out_valid || out_ready)
  `MFBR_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.exec, cmd.issue, cmd.finish}))

endmodule

`default_nettype wire

FILE: dv/msb_first_bit_reader_core_test.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core_test
// Self-checking bench for the MSB-first bit reader core. A directed part hits
// rejected pops and skips, a nine-byte pop, a lowered length that leaves the
// read position past the end, and a length past the byte store. Random phases
// then run write/pop/skip/rewind traffic at several stream lengths and idle
// patterns, plus a long receiver hold-off. A shadow store and read position
// predict every result beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msb_first_bit_reader_core_test;
  import mfbr_pkg::*;

  localparam int STORE_BYTES  = 4096;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_GAP      = 60;
  localparam int SHOW_LIMIT   = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;

  // shadow state of the block
  logic [7:0]          shadow_bytes [STORE_BYTES];
  bit                  byte_written [STORE_BYTES];
  int unsigned         read_pos = 0;
  logic [LEN_W-1:0]    stream_len = '0;

  out_item_t           expected_results [$];
  int unsigned         mismatches = 0;
  int unsigned         gap_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         hold_req = 0;
  int unsigned         hold_left = 0;
  int unsigned         quiet_cycles = 0;

  msb_first_bit_reader_core #(
    .BUF_BYTES(STORE_BYTES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic stream_bit(input int unsigned p);
    if ((p >> 3) >= STORE_BYTES) return 1'b0;
    return shadow_bytes[p >> 3][7 - (p & 7)];
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t   r;
    int unsigned len_bits;
    int unsigned cnt;
    r = '0;
    len_bits = 32'(stream_len) * 8;
    cnt = 32'(it.bit_count);
    case (it.kind)
      KIND_WRITE: begin
        shadow_bytes[it.byte_addr] = it.byte_data;
        byte_written[it.byte_addr] = 1'b1;
        r.ok = 1'b1;
      end
      KIND_POP: begin
        if (cnt >= 1 && cnt <= POP_MAX_BITS && read_pos + cnt <= len_bits) begin
          for (int unsigned i = 0; i < cnt; i++) begin
            r.value = {r.value[VALUE_W-2:0], stream_bit(read_pos + i)};
          end
          read_pos += cnt;
          r.ok = 1'b1;
        end
      end
      KIND_SKIP: begin
        if (read_pos + cnt <= len_bits) begin
          read_pos += cnt;
          r.ok = 1'b1;
        end
      end
      default: begin
        read_pos = 0;
        r.ok = 1'b1;
      end
    endcase
    read_pos &= 32'hFFFF;
    r.at_end = (read_pos == len_bits);
    r.remaining_bytes = (read_pos <= len_bits) ? LEN_W'((len_bits - read_pos) / 8) : '0;
    r.consumed_bytes = LEN_W'((read_pos + 7) / 8);
    return r;
  endfunction

  // first never-written byte a successful pop would read, or -1
  function automatic int first_blank_byte(input int unsigned cnt);
    int unsigned len_bits;
    len_bits = 32'(stream_len) * 8;
    if (cnt == 0 || cnt > POP_MAX_BITS || read_pos + cnt > len_bits) return -1;
    for (int unsigned a = read_pos >> 3; a <= (read_pos + cnt - 1) >> 3; a++) begin
      if (a < STORE_BYTES && !byte_written[a]) return int'(a);
    end
    return -1;
  endfunction

  function automatic in_item_t make_item(input logic [KIND_W-1:0] kind, input int unsigned addr,
                                         input int unsigned data, input int unsigned count);
    in_item_t it;
    it.kind = kind;
    it.byte_addr = addr[ADDR_W-1:0];
    it.byte_data = data[DATA_W-1:0];
    it.bit_count = count[COUNT_W-1:0];
    return it;
  endfunction

  function automatic in_item_t random_stream_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned r;
    int unsigned len_bits;
    int unsigned span;
    int          blank;
    it.kind = KIND_POP;
    it.byte_addr = ADDR_W'($urandom);
    it.byte_data = DATA_W'($urandom);
    it.bit_count = COUNT_W'($urandom);
    len_bits = 32'(stream_len) * 8;
    span = (stream_len > STORE_BYTES) ? STORE_BYTES : 32'(stream_len);
    pick = $urandom_range(99);
    r = $urandom_range(19);
    if (pick < 18) begin
      it.kind = KIND_WRITE;
      if (r > 4 && span != 0) it.byte_addr = ADDR_W'($urandom_range(span - 1, 0));
    end else if (pick < 63) begin
      if (r == 0) it.bit_count = '0;
      else if (r == 1) it.bit_count = COUNT_W'($urandom_range(80, 65));
      else if (r < 6) it.bit_count = POP_MAX_BITS;
      else if (r != 2) it.bit_count = COUNT_W'($urandom_range(64, 1));
      blank = first_blank_byte(32'(it.bit_count));
      if (blank >= 0) begin
        it.kind = KIND_WRITE;
        it.byte_addr = ADDR_W'(blank);
      end
    end else if (pick < 88) begin
      it.kind = KIND_SKIP;
      if (r == 0) it.bit_count = '0;
      else if (r == 2 && read_pos <= len_bits) it.bit_count = COUNT_W'(len_bits - read_pos);
      else if (r == 3 && read_pos <= len_bits)
        it.bit_count = COUNT_W'(len_bits - read_pos + $urandom_range(8, 1));
      else if (r > 3) it.bit_count = COUNT_W'($urandom_range(40, 1));
    end else begin
      it.kind = KIND_REWIND;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < SHOW_LIMIT)
      $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.value !== want.value) report_mismatch("value", got.value, want.value);
    if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
    if (got.at_end !== want.at_end)
      report_mismatch("at_end", 64'(got.at_end), 64'(want.at_end));
    if (got.remaining_bytes !== want.remaining_bytes)
      report_mismatch("remaining_bytes", 64'(got.remaining_bytes),
                      64'(want.remaining_bytes));
    if (got.consumed_bytes !== want.consumed_bytes)
      report_mismatch("consumed_bytes", 64'(got.consumed_bytes),
                      64'(want.consumed_bytes));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) report_mismatch("unexpected beat", out_item.value, '0);
      else check_result(out_item, expected_results.pop_front());
    end
  end

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("msb_first_bit_reader_core: mismatch");
      $finish;
    end
  end

  // called just after a falling edge; returns just after one, valid still up
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_result(it));
    @(negedge clk);
  endtask

  task automatic set_stream_length(input int unsigned len);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len[LEN_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    stream_len = len[LEN_W-1:0];
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 78; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 78; end
      default:       begin gap_pct = 6;  stall_pct = 6;  end
    endcase
  endtask

  task automatic test_reset_state();
    send_item(make_item(KIND_POP, 0, 0, 1));
    send_item(make_item(KIND_SKIP, 0, 0, 0));
  endtask

  task automatic test_pop_bounds();
    logic [7:0] pattern [9];
    pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h3C, 8'hC3, 8'h7E};
    set_stream_length(10);
    for (int i = 0; i < 9; i++) send_item(make_item(KIND_WRITE, i, 32'(pattern[i]), 0));
    send_item(make_item(KIND_POP, 0, 0, 0));
    send_item(make_item(KIND_POP, 0, 0, 65));
    send_item(make_item(KIND_POP, 0, 0, 4));
    send_item(make_item(KIND_POP, 0, 0, 64));
    send_item(make_item(KIND_SKIP, 0, 0, 12));
    send_item(make_item(KIND_POP, 0, 0, 1));
    send_item(make_item(KIND_REWIND, 0, 0, 0));
    send_item(make_item(KIND_SKIP, 0, 0, 'hFFFF));
  endtask

  task automatic test_length_lowered();
    send_item(make_item(KIND_SKIP, 0, 0, 72));
    set_stream_length(4);
    send_item(make_item(KIND_SKIP, 0, 0, 0));
    send_item(make_item(KIND_POP, 0, 0, 8));
    send_item(make_item(KIND_REWIND, 0, 0, 0));
  endtask

  task automatic test_beyond_store();
    set_stream_length(8191);
    send_item(make_item(KIND_WRITE, STORE_BYTES - 1, 'hC3, 0));
    send_item(make_item(KIND_SKIP, 0, 0, 32760));
    send_item(make_item(KIND_POP, 0, 0, 16));
    send_item(make_item(KIND_POP, 0, 0, 64));
    send_item(make_item(KIND_SKIP, 0, 0, 65528 - 32840));
    send_item(make_item(KIND_POP, 0, 0, 1));
    send_item(make_item(KIND_REWIND, 0, 0, 0));
  endtask

  task automatic test_random_stream(input idle_mode_t mode, input int unsigned len,
                                    input int unsigned n);
    set_stream_length(len);
    set_idle(mode);
    repeat (n) send_item(random_stream_item());
  endtask

  task automatic test_backpressure();
    set_stream_length(20);
    set_idle(IDLE_NONE);
    hold_req = 300;
    repeat (120) send_item(random_stream_item());
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_pop_bounds();
    test_length_lowered();
    test_beyond_store();
    test_random_stream(IDLE_NONE, 12, 360);
    test_random_stream(IDLE_SENDER, 4096, 360);
    test_random_stream(IDLE_RECEIVER, 1, 300);
    test_random_stream(IDLE_BOTH, 40, 360);
    test_backpressure();
    test_random_stream(IDLE_BOTH, 0, 40);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("msb_first_bit_reader_core: match");
    end else begin
      $display("msb_first_bit_reader_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mfbr_pkg.sv
rtl/core/mfbr_ctrl.sv
rtl/core/mfbr_dp.sv
rtl/core/msb_first_bit_reader_core.sv
dv/msb_first_bit_reader_core_test.sv
